// ----- hdl/emts_pkg.sv -----
package emts_pkg;

   // commands carried in tuser
   localparam logic CMD_PLACE = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // plant types
   localparam logic TYPE_CROP     = 1'b0;
   localparam logic TYPE_SENTINEL = 1'b1;

   // plant states
   localparam int         NUM_STATES   = 3;
   localparam logic [1:0] ST_HEALTHY   = 2'd0;
   localparam logic [1:0] ST_UNDETECT  = 2'd1;
   localparam logic [1:0] ST_DETECT    = 2'd2;
   localparam logic [1:0] ST_INVALID   = 2'd3;

   // fixed point
   localparam int         PROB_BITS    = 16;
   localparam int         WEIGHT_SHIFT = 12;
   localparam logic [15:0] WEIGHT_ONE  = 16'd4096;

   // csr register indexes
   localparam int         CSR_INDEX_BITS        = 3;
   localparam logic [2:0] CSR_CROP_RATE         = 3'd0;
   localparam logic [2:0] CSR_SENTINEL_RATE     = 3'd1;
   localparam logic [2:0] CSR_CROP_WEIGHT       = 3'd2;
   localparam logic [2:0] CSR_SENTINEL_WEIGHT   = 3'd3;
   localparam logic [2:0] CSR_CROP_DETECT       = 3'd4;
   localparam logic [2:0] CSR_SENTINEL_DETECT   = 3'd5;

   // decision queue
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;

   typedef struct packed {
      logic [15:0] crop_rate;
      logic [15:0] sentinel_rate;
      logic [15:0] crop_weight;
      logic [15:0] sentinel_weight;
      logic [15:0] crop_detect;
      logic [15:0] sentinel_detect;
   } emts_cfg_type;

   typedef struct packed {
      logic       command;
      logic       plant_type;
      logic [1:0] cur_state;
      logic [1:0] next_state;
   } emts_item_type;

endpackage

// ----- hdl/emts_front.sv -----
module emts_front #(
   parameter int LINK_BITS     = 8,
   parameter int REQ_DATA_BITS = 56
) (
   input  logic                       clock,
   input  logic                       reset,
   input  emts_pkg::emts_cfg_type     cfg,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                       req_tuser,
   output logic                       item_valid,
   input  logic                       item_ready,
   output emts_pkg::emts_item_type    item
);

   localparam int WU_BITS = emts_pkg::PROB_BITS + LINK_BITS;
   localparam int W_BITS  = WU_BITS + 1;
   localparam int P_BITS  = emts_pkg::PROB_BITS + W_BITS;
   localparam int T_BITS  = P_BITS - emts_pkg::WEIGHT_SHIFT;
   localparam int F_BITS  = T_BITS + 1;
   localparam int DRAW_LO = 3 + 4 * LINK_BITS;

   // field unpack
   logic                  in_type;
   logic [1:0]            in_cur;
   logic [LINK_BITS-1:0]  in_cu;
   logic [LINK_BITS-1:0]  in_cd;
   logic [LINK_BITS-1:0]  in_su;
   logic [LINK_BITS-1:0]  in_sd;
   logic [15:0]           in_draw;

   assign in_type = req_tdata[0];
   assign in_cur  = req_tdata[2:1];
   assign in_cu   = req_tdata[3 +: LINK_BITS];
   assign in_cd   = req_tdata[3 + LINK_BITS +: LINK_BITS];
   assign in_su   = req_tdata[3 + 2 * LINK_BITS +: LINK_BITS];
   assign in_sd   = req_tdata[3 + 3 * LINK_BITS +: LINK_BITS];
   assign in_draw = req_tdata[DRAW_LO +: 16];

   // stage 1: weighted link sums
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_cmd_ff;
   logic                s1_type_ff;
   logic [1:0]          s1_cur_ff;
   logic [15:0]         s1_draw_ff;
   logic [W_BITS-1:0]   s1_wc_ff, s1_wc_in;
   logic [W_BITS-1:0]   s1_ws_ff, s1_ws_in;
   logic [WU_BITS-1:0]  wu_crop;
   logic [WU_BITS-1:0]  wu_sent;

   // stage 2: rate products and detection decision
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_cmd_ff;
   logic                s2_type_ff;
   logic [1:0]          s2_cur_ff;
   logic [15:0]         s2_draw_ff;
   logic                s2_det_ff, s2_det_in;
   logic [P_BITS-1:0]   s2_pc_ff, s2_pc_in;
   logic [P_BITS-1:0]   s2_ps_ff, s2_ps_in;
   logic [15:0]         det_prob;
   logic [16:0]         det_sum;

   logic                ld1;
   logic                ld2;
   logic                push;

   logic [T_BITS-1:0]   term_crop;
   logic [T_BITS-1:0]   term_sent;
   logic [F_BITS-1:0]   force_sum;
   logic [16:0]         inf_sum;
   logic                inf_hit;
   logic [1:0]          next_state;

   assign push        = s2_valid_ff & item_ready;
   assign ld2         = s1_valid_ff & (~s2_valid_ff | push);
   assign req_tready  = ~s1_valid_ff | ld2;
   assign ld1         = req_tvalid & req_tready;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;
   assign s2_valid_in = (~s2_valid_ff | push) ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      wu_crop  = cfg.crop_weight * in_cu;
      wu_sent  = cfg.sentinel_weight * in_su;
      s1_wc_in = W_BITS'(wu_crop) + (W_BITS'(in_cd) << emts_pkg::WEIGHT_SHIFT);
      s1_ws_in = W_BITS'(wu_sent) + (W_BITS'(in_sd) << emts_pkg::WEIGHT_SHIFT);
   end

   always_comb begin
      det_prob  = (s1_type_ff == emts_pkg::TYPE_SENTINEL) ? cfg.sentinel_detect
                                                          : cfg.crop_detect;
      det_sum   = {1'b0, s1_draw_ff} + {1'b0, det_prob};
      s2_det_in = det_sum[16];
      s2_pc_in  = s1_wc_ff * cfg.crop_rate;
      s2_ps_in  = s1_ws_ff * cfg.sentinel_rate;
   end

   // force saturates at one, so any high bit means certain infection
   always_comb begin
      term_crop = s2_pc_ff[P_BITS-1:emts_pkg::WEIGHT_SHIFT];
      term_sent = s2_ps_ff[P_BITS-1:emts_pkg::WEIGHT_SHIFT];
      force_sum = F_BITS'(term_crop) + F_BITS'(term_sent);
      inf_sum   = {1'b0, s2_draw_ff} + {1'b0, force_sum[15:0]};
      inf_hit   = (force_sum[F_BITS-1:16] != '0) | inf_sum[16];
   end

   always_comb begin
      next_state = s2_cur_ff;
      if (s2_cmd_ff == emts_pkg::CMD_STEP) begin
         unique case (s2_cur_ff)
            emts_pkg::ST_HEALTHY: begin
               next_state = inf_hit ? emts_pkg::ST_UNDETECT : emts_pkg::ST_HEALTHY;
            end
            emts_pkg::ST_UNDETECT: begin
               next_state = s2_det_ff ? emts_pkg::ST_DETECT : emts_pkg::ST_UNDETECT;
            end
            default: begin
               next_state = s2_cur_ff;
            end
         endcase
      end
   end

   assign item_valid      = s2_valid_ff;
   assign item.command    = s2_cmd_ff;
   assign item.plant_type = s2_type_ff;
   assign item.cur_state  = s2_cur_ff;
   assign item.next_state = next_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_cmd_ff  <= req_tuser;
         s1_type_ff <= in_type;
         s1_cur_ff  <= in_cur;
         s1_draw_ff <= in_draw;
         s1_wc_ff   <= s1_wc_in;
         s1_ws_ff   <= s1_ws_in;
      end
      if (ld2) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_type_ff <= s1_type_ff;
         s2_cur_ff  <= s1_cur_ff;
         s2_draw_ff <= s1_draw_ff;
         s2_det_ff  <= s2_det_in;
         s2_pc_ff   <= s2_pc_in;
         s2_ps_ff   <= s2_ps_in;
      end
   end

endmodule

// ----- hdl/emts_queue.sv -----
module emts_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  emts_pkg::emts_item_type  in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output emts_pkg::emts_item_type  out_item
);

   localparam int CNT_BITS = emts_pkg::QUEUE_PTR_BITS + 1;

   emts_pkg::emts_item_type               mem_ff [emts_pkg::QUEUE_DEPTH];
   logic [emts_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [emts_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]                   count_ff, count_in;
   logic                                  push;
   logic                                  pop;

   assign in_ready  = (count_ff != CNT_BITS'(emts_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   // pointers wrap on their own since the depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ----- hdl/emts_back.sv -----
module emts_back #(
   parameter int COUNT_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   output logic                                item_ready,
   input  emts_pkg::emts_item_type             item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          new_state,
   output logic                                changed,
   output logic [5:0][COUNT_BITS-1:0]          counts
);

   logic                              out_valid_ff, out_valid_in;
   logic [1:0]                        out_state_ff;
   logic                              out_changed_ff;
   logic [5:0][COUNT_BITS-1:0]        count_ff, count_in;

   logic        pop;
   logic        item_changed;
   logic        inc_cur;
   logic        dec_cur;
   logic        inc_next;
   logic [2:0]  type_base;
   logic [2:0]  cur_idx;
   logic [2:0]  next_idx;
   logic        do_inc;
   logic        do_dec;

   assign item_ready   = ~out_valid_ff | rsp_ready;
   assign pop          = item_valid & item_ready;
   assign out_valid_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   assign item_changed = (item.command == emts_pkg::CMD_STEP) &
                         (item.next_state != item.cur_state);

   // counter slot is type * 3 + state, crop first
   always_comb begin
      type_base = (item.plant_type == emts_pkg::TYPE_SENTINEL)
                  ? 3'(emts_pkg::NUM_STATES) : 3'd0;
      cur_idx   = type_base + {1'b0, item.cur_state};
      next_idx  = type_base + {1'b0, item.next_state};
      inc_cur   = pop & (item.command == emts_pkg::CMD_PLACE) &
                  (item.cur_state != emts_pkg::ST_INVALID);
      dec_cur   = pop & item_changed;
      inc_next  = pop & item_changed;
   end

   always_comb begin
      do_inc   = 1'b0;
      do_dec   = 1'b0;
      count_in = count_ff;
      for (int i = 0; i < 6; i++) begin
         do_inc = (inc_cur & (cur_idx == 3'(i))) | (inc_next & (next_idx == 3'(i)));
         do_dec = dec_cur & (cur_idx == 3'(i));
         if (do_inc) begin
            if (count_ff[i] != '1) begin
               count_in[i] = count_ff[i] + 1'b1;
            end
         end else if (do_dec) begin
            if (count_ff[i] != '0) begin
               count_in[i] = count_ff[i] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_state_ff   <= item.next_state;
         out_changed_ff <= item_changed;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign new_state = out_state_ff;
   assign changed   = out_changed_ff;
   assign counts    = count_ff;

endmodule

// ----- hdl/epidemic_markov_transition_step.sv -----
// plant epidemic markov step: each req beat is one plant. a place beat (tuser 0) adds the
// plant to the saturating population counter of its type and state; a step beat (tuser 1)
// works out the infection force from the four infected-link counts in q0.16/q4.12 fixed
// point (saturated at 1.0), compares the 16-bit draw with the stay probability and moves
// one count between the six counters when the state changes. every req beat gives one rsp
// beat with the new state, the changed flag and all six counters after the update. one
// beat per cycle is sustained while rsp_tready stays high; the rate is set by the counter
// read-modify-write in the back end. a taken req beat passes through two arithmetic
// stages, the decision queue and the output register before its result is presented.
// a four-entry decision queue between the arithmetic front end and the counter back end
// lets either side stall alone. csr writes are taken every cycle (csr_ready is tied high)
// and must only happen while the block is idle; indexes above five are dropped.
module epidemic_markov_transition_step #(
   parameter int COUNT_BITS = 20,
   parameter int LINK_BITS  = 8
) (
   input  logic                                       clock,
   input  logic                                       reset,

   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // plant_type, current_state, crop_undetectable_links, crop_detectable_links,
   // sentinel_undetectable_links, sentinel_detectable_links, random_draw, zero pad
   input  logic [((4 * LINK_BITS + 26) / 8) * 8-1:0]  req_tdata,
   // command
   input  logic                                       req_tuser,

   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // new_state, changed, crop_healthy_count, crop_undetectable_count,
   // crop_detectable_count, sentinel_healthy_count, sentinel_undetectable_count,
   // sentinel_detectable_count, zero pad
   output logic [((6 * COUNT_BITS + 10) / 8) * 8-1:0] rsp_tdata,

   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [emts_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [15:0]                                csr_data
);

   localparam int REQ_DATA_BITS = ((4 * LINK_BITS + 26) / 8) * 8;
   localparam int RSP_DATA_BITS = ((6 * COUNT_BITS + 10) / 8) * 8;

   // configuration registers
   emts_pkg::emts_cfg_type  cfg_ff, cfg_in;

   // front to queue
   logic                     fq_valid;
   logic                     fq_ready;
   emts_pkg::emts_item_type  fq_item;

   // queue to back
   logic                     qb_valid;
   logic                     qb_ready;
   emts_pkg::emts_item_type  qb_item;

   // back outputs
   logic [1:0]                    bk_state;
   logic                          bk_changed;
   logic [5:0][COUNT_BITS-1:0]    bk_counts;

   assign csr_ready = 1'b1;

   // register file write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            emts_pkg::CSR_CROP_RATE:       cfg_in.crop_rate       = csr_data;
            emts_pkg::CSR_SENTINEL_RATE:   cfg_in.sentinel_rate   = csr_data;
            emts_pkg::CSR_CROP_WEIGHT:     cfg_in.crop_weight     = csr_data;
            emts_pkg::CSR_SENTINEL_WEIGHT: cfg_in.sentinel_weight = csr_data;
            emts_pkg::CSR_CROP_DETECT:     cfg_in.crop_detect     = csr_data;
            emts_pkg::CSR_SENTINEL_DETECT: cfg_in.sentinel_detect = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crop_rate       <= '0;
         cfg_ff.sentinel_rate   <= '0;
         cfg_ff.crop_weight     <= emts_pkg::WEIGHT_ONE;
         cfg_ff.sentinel_weight <= emts_pkg::WEIGHT_ONE;
         cfg_ff.crop_detect     <= '0;
         cfg_ff.sentinel_detect <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: unpack, force and detection arithmetic, next-state decision
   emts_front #(
      .LINK_BITS     (LINK_BITS),
      .REQ_DATA_BITS (REQ_DATA_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (fq_valid),
      .item_ready (fq_ready),
      .item       (fq_item)
   );

   // decisions wait here while the back end or the rsp side stalls
   emts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_item  (qb_item)
   );

   // back end: counter update and rsp output register
   emts_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (qb_valid),
      .item_ready (qb_ready),
      .item       (qb_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .new_state  (bk_state),
      .changed    (bk_changed),
      .counts     (bk_counts)
   );

   // counters sit above the state and flag, pad bits are zero
   assign rsp_tdata = RSP_DATA_BITS'({bk_counts, bk_changed, bk_state});

`ifndef NO_ASSERTIONS
   // nothing is presented right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp beat presented right after reset");

   // a held result and the counters only move when the back end takes a decision
   a_hold_without_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !(qb_valid && qb_ready)) |=> $stable(rsp_tdata))
      else $error("rsp payload moved without a queue pop");

   // a change always lands in an infected state
   a_change_is_infection: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2]) |->
         (rsp_tdata[1:0] == emts_pkg::ST_UNDETECT || rsp_tdata[1:0] == emts_pkg::ST_DETECT))
      else $error("changed flag set on a non-infected state");
`endif

endmodule
